>>> rtl/b32e_pkg.sv
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and functions of the Bech32 checksum encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  localparam int MAX_STRING_LEN = 90;
  localparam int MAX_PREFIX_LEN = 83;
  localparam int POSTFIX_LEN    = 6;
  localparam int COUNT_CAP      = 127;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam int CHAR_W      = 7;
  localparam int SYM_W       = 5;
  localparam int ACC_W       = 30;
  localparam int TOTAL_W     = 7;
  localparam int PFX_ADDR_W  = $clog2(MAX_PREFIX_LEN);
  localparam int PFX_CNT_W   = $clog2(MAX_PREFIX_LEN + 1);
  localparam int CHK_IDX_W   = $clog2(POSTFIX_LEN);
  localparam int FIFO_PTR_W  = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W  = $clog2(CMD_FIFO_DEPTH + 1);

  localparam logic [ACC_W-1:0]  BECH32_CONST  = 30'h0000_0001;
  localparam logic [ACC_W-1:0]  BECH32M_CONST = 30'h2bc8_30a3;
  localparam logic [ACC_W-1:0]  ACC_INIT      = 30'h0000_0001;
  localparam logic [CHAR_W-1:0] SEPARATOR     = 7'h31;

  localparam logic REQ_PREFIX = 1'b0;
  localparam logic REQ_DATA   = 1'b1;

  localparam logic [ACC_W-1:0] GEN_POLY [SYM_W] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [7:0] CHARSET [32] = '{
    "q", "p", "z", "r", "y", "9", "x", "8", "g", "f", "2", "t", "v", "d", "w", "0",
    "s", "3", "j", "n", "5", "4", "k", "h", "c", "e", "6", "m", "u", "a", "7", "l"
  };

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] value;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              too_long;
    logic              end_of_string;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_PREFIX     = 2'd0,
    CMD_FIRST_DATA = 2'd1,
    CMD_DATA       = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] value;
    logic              last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_REPLAY = 3'd1,
    ST_SEP    = 3'd2,
    ST_DATA   = 3'd3,
    ST_CHECK  = 3'd4
  } back_state_t;

  // One polymod step: shift in a 5-bit symbol, reduce by the generator.
  function automatic logic [ACC_W-1:0] polymod_fold(logic [ACC_W-1:0] acc,
                                                    logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] top;
    logic [ACC_W-1:0] r;
    top = acc[ACC_W-1 -: SYM_W];
    r   = {acc[ACC_W-SYM_W-1:0], sym};
    for (int j = 0; j < SYM_W; j++) begin
      if (top[j]) begin
        r = r ^ GEN_POLY[j];
      end
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] sym_char(logic [SYM_W-1:0] sym);
    logic [7:0] c;
    c = CHARSET[sym];
    return c[CHAR_W-1:0];
  endfunction

endpackage

>>> rtl/b32e_ram.sv
// ----------------------------------------------------------------------------
// b32e_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module b32e_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/b32e_front.sv
// ----------------------------------------------------------------------------
// b32e_front
// Input stage: accept items, drop stray prefix characters, tag the first
// data symbol of each string, and push commands into the queue.
// ----------------------------------------------------------------------------
module b32e_front
  import b32e_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     fifo_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic in_data;
  logic in_data_next;
  logic accept;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push           = 1'b0;
    push_cmd.kind  = CMD_PREFIX;
    push_cmd.value = in_item.value;
    push_cmd.last  = in_item.last;
    in_data_next   = in_data;
    if (accept) begin
      if (in_item.req_type == REQ_PREFIX) begin
        // prefix characters inside the data part are dropped
        push          = !in_data;
        push_cmd.last = 1'b0;
      end else begin
        push          = 1'b1;
        push_cmd.kind = in_data ? CMD_DATA : CMD_FIRST_DATA;
        in_data_next  = !in_item.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data <= 1'b0;
    end else begin
      in_data <= in_data_next;
    end
  end

endmodule

>>> rtl/b32e_cmd_fifo.sv
// ----------------------------------------------------------------------------
// b32e_cmd_fifo
// Short command queue between the input stage and the encoder engine.
// ----------------------------------------------------------------------------
module b32e_cmd_fifo
  import b32e_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic cmd_valid,
  output cmd_t cmd
);

  cmd_t                  entries [CMD_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (count == FIFO_CNT_W'(CMD_FIFO_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && cmd_valid;

  function automatic logic [FIFO_PTR_W-1:0] wrap_inc(logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/b32e_back.sv
// ----------------------------------------------------------------------------
// b32e_back
// Encoder engine: prefix buffer, polymod accumulator, length check,
// checksum emission and the output register.
// ----------------------------------------------------------------------------
module b32e_back
  import b32e_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [ACC_W-1:0] final_const,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  back_state_t          state;
  back_state_t          state_next;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     acc_next;
  logic [PFX_CNT_W-1:0] prefix_count;
  logic [PFX_CNT_W-1:0] prefix_count_next;
  logic [TOTAL_W-1:0]   total_count;
  logic [TOTAL_W-1:0]   total_inc;
  logic                 overflow_seen;
  logic                 overflow_next;
  logic [PFX_CNT_W-1:0] replay_idx;
  logic [PFX_CNT_W-1:0] replay_idx_next;
  logic [SYM_W-1:0]     cur_sym;
  logic                 cur_last;
  logic [ACC_W-1:0]     chk_sr;
  logic [ACC_W-1:0]     chk_sr_next;
  logic [CHK_IDX_W-1:0] chk_idx;
  logic [CHK_IDX_W-1:0] chk_idx_next;
  logic                 slot_free;
  logic                 emit;
  out_item_t            emit_item;
  logic                 count_en;
  logic                 pfx_over;
  logic                 latch_cmd;
  logic                 clear_str;
  logic                 ram_we;
  logic [PFX_ADDR_W-1:0] ram_waddr;
  logic [PFX_ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0]    ram_rdata;
  logic [PFX_CNT_W-1:0] idx_plus;
  logic                 pfx_room;
  logic                 chk_final;

  assign slot_free = !out_valid || out_ready;
  assign total_inc = (total_count == TOTAL_W'(COUNT_CAP)) ? total_count
                                                          : total_count + 1'b1;
  assign overflow_next = overflow_seen || pfx_over ||
                         (count_en && (({1'b0, total_inc} + 8'(POSTFIX_LEN)) >
                                       8'(MAX_STRING_LEN)));
  assign idx_plus  = replay_idx + 1'b1;
  assign pfx_room  = (prefix_count < PFX_CNT_W'(MAX_PREFIX_LEN));
  assign chk_final = (chk_idx == CHK_IDX_W'(POSTFIX_LEN - 1));

  b32e_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_PREFIX_LEN)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_FIRST_DATA: state_next = ST_REPLAY;
            CMD_DATA: begin
              if (slot_free && cmd.last) begin
                state_next = ST_CHECK;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_REPLAY: begin
        if (replay_idx == prefix_count) begin
          state_next = ST_SEP;
        end
      end
      ST_SEP: begin
        if (slot_free) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          state_next = cur_last ? ST_CHECK : ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (slot_free && chk_final) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath controls and next values
  always_comb begin
    pop               = 1'b0;
    emit              = 1'b0;
    emit_item         = '0;
    count_en          = 1'b0;
    pfx_over          = 1'b0;
    latch_cmd         = 1'b0;
    clear_str         = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = prefix_count[PFX_ADDR_W-1:0];
    ram_raddr         = '0;
    acc_next          = acc;
    prefix_count_next = prefix_count;
    replay_idx_next   = replay_idx;
    chk_sr_next       = chk_sr;
    chk_idx_next      = chk_idx;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_PREFIX: begin
              if (slot_free) begin
                pop      = 1'b1;
                count_en = 1'b1;
                if (pfx_room) begin
                  ram_we            = 1'b1;
                  acc_next          = polymod_fold(acc, SYM_W'(cmd.value[CHAR_W-1:SYM_W]));
                  prefix_count_next = prefix_count + 1'b1;
                end else begin
                  pfx_over = 1'b1;
                end
                emit               = 1'b1;
                emit_item.out_char = cmd.value;
              end
            end
            CMD_FIRST_DATA: begin
              // fold the zero between the high and low halves, start replay
              pop             = 1'b1;
              latch_cmd       = 1'b1;
              acc_next        = polymod_fold(acc, '0);
              replay_idx_next = '0;
            end
            CMD_DATA: begin
              if (slot_free) begin
                pop                = 1'b1;
                count_en           = 1'b1;
                acc_next           = polymod_fold(acc, cmd.value[SYM_W-1:0]);
                emit               = 1'b1;
                emit_item.out_char = sym_char(cmd.value[SYM_W-1:0]);
                chk_sr_next        = acc_next ^ final_const;
                chk_idx_next       = '0;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_REPLAY: begin
        if (replay_idx != prefix_count) begin
          acc_next        = polymod_fold(acc, ram_rdata[SYM_W-1:0]);
          replay_idx_next = idx_plus;
          if (idx_plus < prefix_count) begin
            ram_raddr = idx_plus[PFX_ADDR_W-1:0];
          end
        end
      end
      ST_SEP: begin
        if (slot_free) begin
          count_en           = 1'b1;
          emit               = 1'b1;
          emit_item.out_char = SEPARATOR;
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          count_en           = 1'b1;
          acc_next           = polymod_fold(acc, cur_sym);
          emit               = 1'b1;
          emit_item.out_char = sym_char(cur_sym);
          chk_sr_next        = acc_next ^ final_const;
          chk_idx_next       = '0;
        end
      end
      ST_CHECK: begin
        if (slot_free) begin
          emit                    = 1'b1;
          emit_item.out_char      = sym_char(chk_sr[ACC_W-1 -: SYM_W]);
          emit_item.end_of_string = chk_final;
          chk_sr_next             = {chk_sr[ACC_W-SYM_W-1:0], {SYM_W{1'b0}}};
          chk_idx_next            = chk_idx + 1'b1;
          clear_str               = chk_final;
        end
      end
      default: pop = 1'b0;
    endcase
    emit_item.too_long = overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      acc           <= ACC_INIT;
      prefix_count  <= '0;
      total_count   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_str) begin
        acc           <= ACC_INIT;
        prefix_count  <= '0;
        total_count   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        acc           <= acc_next;
        prefix_count  <= prefix_count_next;
        overflow_seen <= overflow_next;
        if (count_en) begin
          total_count <= total_inc;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    replay_idx <= replay_idx_next;
    chk_sr     <= chk_sr_next;
    chk_idx    <= chk_idx_next;
    if (latch_cmd) begin
      cur_sym  <= cmd.value[SYM_W-1:0];
      cur_last <= cmd.last;
    end
    if (emit) begin
      out_item <= emit_item;
    end
  end

endmodule

>>> rtl/bech32_checksum_encoder_core.sv
// ----------------------------------------------------------------------------
// bech32_checksum_encoder_core
// Streaming Bech32 / Bech32m string encoder with checksum generation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_item): prefix characters first, then
//   5-bit data symbols, the final one with last set. Each transfer yields its
//   characters on the output channel (out_valid/out_ready/out_item): the
//   prefix echoed, the separator '1', one charset character per symbol and
//   six checksum characters, the final one flagged with end_of_string.
//   too_long rises once the string is known to exceed the length limit; the
//   string is still emitted in full.
//   Path: each item passes the command queue, then the output register.
//   Throughput: one prefix character or data symbol per cycle while the
//   output is not stalled. The first data symbol first folds the zero, then
//   the engine replays the buffered prefix (stored length capped at the
//   prefix buffer size) from its RAM one character per cycle, then emits
//   the separator. The last symbol is followed by the six checksum
//   characters. Reset clears the variant register (Bech32), the queue,
//   the state, accumulator, counts, overflow flag and output valid of the
//   engine and the data flag of the input stage. When the receiver stalls,
//   the output register holds its character and the engine waits; the
//   command queue keeps taking input until full.
//   Write checksum_variant (cfg_write_en/cfg_write_data) only while idle.
// ----------------------------------------------------------------------------
module bech32_checksum_encoder_core
  import b32e_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write_en,
  input  logic      cfg_write_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // 0 selects Bech32, 1 selects Bech32m
  logic             checksum_variant;
  logic [ACC_W-1:0] final_const;

  // front to queue
  logic fifo_full;
  logic push;
  cmd_t push_cmd;

  // queue to engine
  logic cmd_valid;
  cmd_t cmd;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_variant <= 1'b0;
    end else if (cfg_write_en) begin
      checksum_variant <= cfg_write_data;
    end
  end

  assign final_const = checksum_variant ? BECH32M_CONST : BECH32_CONST;

  // Classify items; drop prefix characters that arrive inside a data part.
  b32e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Decouple input acceptance from the replay and checksum phases.
  b32e_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Fold symbols, replay the prefix, emit characters through the output reg.
  b32e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .final_const (final_const),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming Bech32 / Bech32m encoder. A queue of
// prefix characters and data symbols feeds a valid/ready driver. A clocked
// monitor predicts the encoded characters of every transfer and compares
// each output transfer against them, field by field. Both variants and
// random stalls on both sides are covered.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b32e_pkg::*;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal silence is a full prefix replay plus separator and pipeline delay,
  // stretched by random gaps on both sides.
  localparam int QUIET_LIMIT = 3000;
  // Settle time after the last character.
  localparam int SETTLE_CYCLES = 10;
  localparam int IDLE_PCT = 17;

  localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_write_en = 1'b0;
  logic      cfg_write_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  bech32_checksum_encoder_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Encoder state mirrored by the bench
  // --------------------------------------------------------------------------
  bit                variant_m = 1'b0;
  logic [ACC_W-1:0]  poly_acc = ACC_INIT;
  logic [CHAR_W-1:0] hrp_mem [MAX_PREFIX_LEN];
  int                hrp_len = 0;
  int                str_len = 0;
  bit                in_data = 1'b0;
  bit                too_long_m = 1'b0;

  in_item_t  feed_q [$];     // symbols waiting to be driven
  out_item_t enc_chars_q [$]; // encoded characters still owed by the block
  out_item_t head;

  bit in_taken = 1'b0;  // input transfer at the last rising edge
  bit steady = 1'b0;    // suppress random idling on both sides
  int mismatches = 0;
  int quiet = 0;

  // One BCH polymod step over GF(32).
  function automatic logic [ACC_W-1:0] bch_shift(logic [ACC_W-1:0] acc,
                                                 logic [SYM_W-1:0] sym);
    logic [ACC_W-1:0] r;
    r = {acc[ACC_W-SYM_W-1:0], sym};
    for (int j = 0; j < SYM_W; j++) begin
      if (acc[ACC_W-SYM_W+j]) begin
        r = r ^ GEN_POLY[j];
      end
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] alpha(logic [SYM_W-1:0] sym);
    return ALPHABET[8*(31-sym) +: CHAR_W];
  endfunction

  function automatic void start_string();
    poly_acc   = ACC_INIT;
    hrp_len    = 0;
    str_len    = 0;
    in_data    = 1'b0;
    too_long_m = 1'b0;
  endfunction

  // Count one emitted string character; the checksum is always six more.
  function automatic void count_char();
    if (str_len < COUNT_CAP) begin
      str_len++;
    end
    if (str_len + POSTFIX_LEN > MAX_STRING_LEN) begin
      too_long_m = 1'b1;
    end
  endfunction

  function automatic void emit(logic [CHAR_W-1:0] ch, logic eos);
    out_item_t o;
    o.out_char      = ch;
    o.too_long      = too_long_m;
    o.end_of_string = eos;
    enc_chars_q.push_back(o);
  endfunction

  // Work out the characters one accepted symbol must produce.
  function automatic void encode_item(in_item_t it);
    logic [ACC_W-1:0] chk;
    if (it.req_type == REQ_PREFIX) begin
      // Prefix characters arriving after the data part has begun are dropped.
      if (!in_data) begin
        if (hrp_len < MAX_PREFIX_LEN) begin
          hrp_mem[hrp_len] = it.value;
          poly_acc = bch_shift(poly_acc, {3'b000, it.value[6:5]});
          hrp_len++;
        end else begin
          // Beyond the buffer: echoed and counted, never checksummed.
          too_long_m = 1'b1;
        end
        count_char();
        emit(it.value, 1'b0);
      end
    end else begin
      if (!in_data) begin
        // First symbol: zero separator, replay the low prefix bits, emit '1'.
        poly_acc = bch_shift(poly_acc, '0);
        for (int i = 0; i < hrp_len; i++) begin
          poly_acc = bch_shift(poly_acc, hrp_mem[i][SYM_W-1:0]);
        end
        in_data = 1'b1;
        count_char();
        emit(SEPARATOR, 1'b0);
      end
      poly_acc = bch_shift(poly_acc, it.value[SYM_W-1:0]);
      count_char();
      emit(alpha(it.value[SYM_W-1:0]), 1'b0);
      if (it.last) begin
        chk = poly_acc ^ (variant_m ? BECH32M_CONST : BECH32_CONST);
        for (int k = 0; k < POSTFIX_LEN; k++) begin
          emit(alpha(chk[SYM_W*(POSTFIX_LEN-1-k) +: SYM_W]), k == POSTFIX_LEN - 1);
        end
        start_string();
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("tb_top: mismatch on %s: got 0x%0h, want 0x%0h at %0t", what, got, want,
             $realtime);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: launch a new transfer at the falling edge once the previous one
  // is gone, idling at random unless the steady stretch is on.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (!rst && feed_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_item  <= feed_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every input transfer, check every output transfer,
  // and watch for a hang. The watchdog stays last in the block.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        encode_item(in_item);
      end
      if (out_valid && out_ready) begin
        if (enc_chars_q.size() == 0) begin
          report_mismatch("unrequested out_char", int'(out_item.out_char), 0);
        end else begin
          head = enc_chars_q.pop_front();
          if (out_item.out_char != head.out_char) begin
            report_mismatch("out_char", int'(out_item.out_char), int'(head.out_char));
          end
          if (out_item.too_long != head.too_long) begin
            report_mismatch("too_long", int'(out_item.too_long), int'(head.too_long));
          end
          if (out_item.end_of_string != head.end_of_string) begin
            report_mismatch("end_of_string", int'(out_item.end_of_string),
                            int'(head.end_of_string));
          end
        end
      end
      if (in_taken || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_item(logic req, logic [CHAR_W-1:0] val, logic fin);
    in_item_t it;
    it.req_type = req;
    it.value    = val;
    it.last     = fin;
    feed_q.push_back(it);
  endfunction

  // Queue one well-formed string with random content; now and then slip an
  // ignored prefix character into the data part. Returns the symbols that
  // actually count as work.
  function automatic int queue_string(int plen, int dlen);
    int n;
    n = 0;
    for (int i = 0; i < plen; i++) begin
      add_item(REQ_PREFIX, CHAR_W'($urandom_range(127)), 1'($urandom_range(1)));
      n++;
    end
    for (int i = 0; i < dlen; i++) begin
      if (i > 0 && $urandom_range(19) == 0) begin
        add_item(REQ_PREFIX, CHAR_W'($urandom_range(127)), 1'($urandom_range(1)));
      end
      add_item(REQ_DATA,
               ($urandom_range(3) == 0) ? CHAR_W'($urandom_range(127))
                                        : CHAR_W'($urandom_range(31)),
               i == dlen - 1);
      n++;
    end
    return n;
  endfunction

  // Mostly short strings; some long prefixes and some data parts long
  // enough to push past the length limit.
  task automatic queue_random(int budget);
    int made;
    int plen;
    int dlen;
    made = 0;
    while (made < budget) begin
      case ($urandom_range(7))
        0:       plen = 0;
        1:       plen = $urandom_range(40, 13);
        default: plen = $urandom_range(10, 1);
      endcase
      dlen = ($urandom_range(5) == 0) ? $urandom_range(80, 30) : $urandom_range(20, 1);
      made += queue_string(plen, dlen);
    end
  endtask

  // Hold until every symbol is transferred and every character has come
  // back, then let the block settle.
  task automatic drain();
    while (feed_q.size() != 0 || in_valid || enc_chars_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_variant(bit v);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    variant_m = v;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings under the reset variant (Bech32).
    // Prefix extremes, last on a prefix character, both data extremes, a
    // prefix character inside the data part and a wide data symbol.
    add_item(REQ_PREFIX, 7'h00, 1'b0);
    add_item(REQ_PREFIX, 7'h7f, 1'b1);
    add_item(REQ_PREFIX, CHAR_W'("b"), 1'b0);
    add_item(REQ_DATA, 7'h00, 1'b0);
    add_item(REQ_DATA, 7'h1f, 1'b0);
    add_item(REQ_PREFIX, CHAR_W'("x"), 1'b0);
    add_item(REQ_DATA, 7'h7f, 1'b1);
    // Empty prefix: the string opens with the separator.
    add_item(REQ_DATA, 7'h15, 1'b1);
    // Ordinary prefix with a wide symbol carrying high bits only.
    add_item(REQ_PREFIX, CHAR_W'("b"), 1'b0);
    add_item(REQ_PREFIX, CHAR_W'("c"), 1'b0);
    add_item(REQ_DATA, 7'h60, 1'b1);
    drain();

    // Bech32m with random idling on both sides.
    write_variant(1'b1);
    queue_random(150);
    drain();

    // Back to Bech32, no idling at all; stop feeding halfway until every
    // character is back.
    write_variant(1'b0);
    steady = 1'b1;
    queue_random(75);
    drain();
    queue_random(75);
    drain();
    steady = 1'b0;

    // Bech32m again: one oversized string that overruns the prefix buffer
    // and saturates the length count, then random strings.
    write_variant(1'b1);
    void'(queue_string(MAX_PREFIX_LEN + 5, 40));
    queue_random(50);
    drain();

    if (mismatches == 0 && enc_chars_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/b32e_pkg.sv
rtl/b32e_ram.sv
rtl/b32e_front.sv
rtl/b32e_cmd_fifo.sv
rtl/b32e_back.sv
rtl/bech32_checksum_encoder_core.sv
test/tb_top.sv
